@@ src/fqr_pkg.sv @@
// shared types and constants for the fifo queue with remove-by-value
// no dependencies
package fqr_pkg;

   localparam int DATA_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
   } dp_status_type;

endpackage

@@ src/fifo_queue_with_remove_by_value_unit.sv @@
// push/pop: word accepted, then execute, strobe on the next; no new word while busy
// remove-by-value: execute, then one pass over the held entries through the store,
// one read and at most one write a cycle, dropping every entry equal to the value,
// then the strobe; an empty queue skips the pass, and no match gives status missing
// reset: synchronous, active high; queue empty, store contents undefined
// the receiver cannot stall: each result is strobed for exactly one cycle
module fifo_queue_with_remove_by_value_unit #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [fqr_pkg::MODE_W-1:0]   req_mode,
   input  logic signed [fqr_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic signed [fqr_pkg::DATA_W-1:0]   rsp_data,
   output logic        [fqr_pkg::STATUS_W-1:0] rsp_status,
   output logic        [fqr_pkg::OCC_W-1:0]    rsp_occupancy
);
   import fqr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   fqr_control u_control (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   fqr_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_data      (rsp_data),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

@@ src/fqr_datapath.sv @@
// queue store, pointers, count and remove-by-value scan/compaction
// depends on fqr_pkg
module fqr_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fqr_pkg::dp_cmd_type                   cmd,
   output fqr_pkg::dp_status_type                stat,
   input  logic        [fqr_pkg::MODE_W-1:0]     req_mode,
   input  logic signed [fqr_pkg::DATA_W-1:0]     req_value,
   output logic signed [fqr_pkg::DATA_W-1:0]     rsp_data,
   output logic        [fqr_pkg::STATUS_W-1:0]   rsp_status,
   output logic        [fqr_pkg::OCC_W-1:0]      rsp_occupancy
);
   import fqr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic signed [DATA_W-1:0] mem [DEPTH];

   logic [MODE_W-1:0]        mode_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [PTR_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]         issued_ff, issued_in;
   logic [CNT_W-1:0]         kept_ff, kept_in;
   logic                     hit_ff, hit_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic                     pop_ok_ff, pop_ok_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [DATA_W-1:0] rd_data_ff;

   logic                     mem_we;
   logic [PTR_W-1:0]         mem_wa;
   logic signed [DATA_W-1:0] mem_wd;
   logic                     mem_re;
   logic [PTR_W-1:0]         mem_ra;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      issued_in   = issued_ff;
      kept_in     = kept_ff;
      hit_in      = hit_ff;
      rd_valid_in = 1'b0;
      pop_ok_in   = pop_ok_ff;
      status_in   = status_ff;
      mem_we      = 1'b0;
      mem_wa      = tail_ff;
      mem_wd      = key_ff;
      mem_re      = 1'b0;
      mem_ra      = head_ff;

      if (cmd.exec) begin
         pop_ok_in = 1'b0;
         status_in = ST_OK;
         rd_ptr_in = head_ff;
         wr_ptr_in = head_ff;
         issued_in = '0;
         kept_in   = '0;
         hit_in    = 1'b0;
         unique case (mode_ff)
            MODE_PUSH: begin
               if (count_ff == CNT_FULL) begin
                  status_in = ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  tail_in  = wrap_next(tail_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            MODE_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  mem_re    = 1'b1;
                  pop_ok_in = 1'b1;
                  head_in   = wrap_next(head_ff);
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            MODE_REMOVE: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end

      if (cmd.scan) begin
         if (issued_ff != count_ff) begin
            mem_re      = 1'b1;
            mem_ra      = rd_ptr_ff;
            rd_ptr_in   = wrap_next(rd_ptr_ff);
            issued_in   = issued_ff + CNT_W'(1);
            rd_valid_in = 1'b1;
         end
         if (rd_valid_ff) begin
            if (rd_data_ff == key_ff) begin
               hit_in = 1'b1;
            end else begin
               mem_we    = 1'b1;
               mem_wa    = wr_ptr_ff;
               mem_wd    = rd_data_ff;
               wr_ptr_in = wrap_next(wr_ptr_ff);
               kept_in   = kept_ff + CNT_W'(1);
            end
         end
      end

      if (cmd.commit) begin
         if (hit_ff) begin
            status_in = ST_OK;
            count_in  = kept_ff;
            tail_in   = wr_ptr_ff;
         end else begin
            status_in = ST_MISSING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
      if (cmd.load) begin
         mode_ff <= req_mode;
         key_ff  <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         issued_ff   <= '0;
         kept_ff     <= '0;
         hit_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
         pop_ok_ff   <= 1'b0;
         status_ff   <= ST_OK;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         issued_ff   <= issued_in;
         kept_ff     <= kept_in;
         hit_ff      <= hit_in;
         rd_valid_ff <= rd_valid_in;
         pop_ok_ff   <= pop_ok_in;
         status_ff   <= status_in;
      end
   end

   assign stat.need_scan = (mode_ff == MODE_REMOVE) && (count_ff != '0);
   assign stat.scan_done = (issued_ff == count_ff) && !rd_valid_ff;

   assign rsp_data      = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = OCC_W'(count_ff);

endmodule

@@ src/fqr_control.sv @@
// request sequencer: accept, execute, scan, respond
// depends on fqr_pkg
module fqr_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   output fqr_pkg::dp_cmd_type    cmd,
   input  fqr_pkg::dp_status_type stat
);
   import fqr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_scan ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               cmd.commit = 1'b1;
               state_in   = S_RESP;
            end
         end
         S_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
